[hw/rtl/mrpt_pkg.sv]
// Shared constants and witness function for the Miller-Rabin prime test unit.
package mrpt_pkg;

  localparam int NumberBitsDefault   = 32;
  localparam int WitnessCountDefault = 8;
  localparam int WitnessTableSize    = 8;
  localparam int InputBits           = 32;

  // Fixed witnesses, in increasing order.
  function automatic logic [4:0] witness_value(input logic [2:0] idx);
    logic [4:0] w;
    begin
      case (idx)
        3'd0: w = 5'd2;
        3'd1: w = 5'd3;
        3'd2: w = 5'd5;
        3'd3: w = 5'd7;
        3'd4: w = 5'd11;
        3'd5: w = 5'd13;
        3'd6: w = 5'd17;
        default: w = 5'd19;
      endcase
      return w;
    end
  endfunction

endpackage

[hw/rtl/miller_rabin_prime_test_unit.sv]
// Top level of the Miller-Rabin prime test unit (fixed witnesses).
//
//  channel   signals              direction  notes
//  command   start, number        in         taken when start && !busy
//  result    done, is_prime       out        one-cycle strobe, no back-pressure
//
// Work: a modular product runs on the single shift-and-add reducer, one bit of the
// multiplier per step (one conditional double and one conditional add per cycle),
// plus sequencer states. Each witness needs at most one product and one square per
// bit of q plus up to k squarings, about 2*NUMBER_BITS products. Even inputs, 1 and
// 0 go from acceptance straight to the final state, from which done is registered.
// The shared mod-multiplier sets the rate.
// Reset: rst (synchronous) returns the sequencer to idle; no clearing pass.
// Stalls: busy is high from acceptance until done rises; a new transaction can be
// taken in the done cycle. The receiver cannot stall, so done is a one-cycle strobe.
module miller_rabin_prime_test_unit #(
  parameter int NUMBER_BITS   = mrpt_pkg::NumberBitsDefault,
  parameter int WITNESS_COUNT = mrpt_pkg::WitnessCountDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mrpt_pkg::InputBits-1:0] number,
  output logic                           busy,
  output logic                           done,
  output logic                           is_prime
);

  localparam int NB = NUMBER_BITS;
  localparam int CW = $clog2(NB + 1);   // bit counter / shift count width
  localparam int WI = 4;                // witness index width (table of 8, one past end)
  localparam int WLast = (WITNESS_COUNT < mrpt_pkg::WitnessTableSize)
                         ? WITNESS_COUNT : mrpt_pkg::WitnessTableSize;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STRIP,     // shift q right until odd, counting k
    S_WIT,       // pick next witness or finish
    S_POW_MUL,   // res = res*b
    S_POW_SQ,    // b = b*b, exp >>= 1
    S_CHECK,     // check x against 1 / n-1
    S_SQ,        // x = x*x
    S_DONE
  } state_t;

  // Shared modular multiplier: acc = a*b mod n, MSB first, one bit a cycle.
  typedef enum logic [1:0] {
    M_RES,
    M_B,
    M_X
  } mdst_t;

  state_t       state;
  mdst_t        mdst;
  logic [NB-1:0] n, q, e, res, b, a_op, b_op, acc;
  logic [CW-1:0] k, i, mcnt;
  logic [WI-1:0] widx;
  logic          mact;
  logic          verdict;
  logic [NB:0]   dbl, dbl_r, add_s, add_r;
  logic [NB-1:0] n_in;
  logic [NB-1:0] nm1;
  logic [NB-1:0] wv;

  assign n_in = NB'(number);
  assign nm1  = n - NB'(1);
  assign wv   = NB'(mrpt_pkg::witness_value(widx[2:0]));

  // One step of the reducer: acc = 2*acc mod n, then + a if bit set.
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
    add_s = dbl_r + {1'b0, a_op};
    add_r = (add_s >= {1'b0, n}) ? add_s - {1'b0, n} : add_s;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    done <= !rst && (state == S_DONE);
    if (rst) begin
      state <= S_IDLE;
      mact  <= 1'b0;
    end else if (mact) begin
      acc  <= b_op[NB-1] ? add_r[NB-1:0] : dbl_r[NB-1:0];
      b_op <= {b_op[NB-2:0], 1'b0};
      mcnt <= mcnt - CW'(1);
      if (mcnt == CW'(1)) begin
        mact <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n <= n_in;
            if (!n_in[0] || n_in == NB'(1)) begin
              is_prime <= (n_in == NB'(2));
              state    <= S_DONE;
            end else begin
              q     <= n_in - NB'(1);
              k     <= '0;
              widx  <= '0;
              state <= S_STRIP;
            end
          end
        end
        S_STRIP: begin
          if (q[0]) begin
            state <= S_WIT;
          end else begin
            q <= q >> 1;
            k <= k + CW'(1);
          end
        end
        S_WIT: begin
          if (32'(widx) >= WLast || wv >= n) begin
            is_prime <= 1'b1;
            state    <= S_DONE;
          end else begin
            res   <= NB'(1);
            b     <= wv;   // w < n already
            e     <= q;
            state <= S_POW_MUL;
          end
        end
        S_POW_MUL: begin
          if (e == '0) begin
            res   <= res;
            i     <= '0;
            state <= S_CHECK;
          end else if (e[0]) begin
            // b from the square just finished is still in acc
            a_op  <= res; b_op <= (mdst == M_B) ? acc : b; acc <= '0; mcnt <= CW'(NB);
            mact  <= 1'b1; mdst <= M_RES;
            state <= S_POW_SQ;
          end else begin
            state <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          if (mdst == M_RES && e[0]) begin
            res <= acc;
          end
          a_op <= b; b_op <= b; acc <= '0; mcnt <= CW'(NB);
          mact <= 1'b1; mdst <= M_B;
          e    <= e >> 1;
          state <= S_POW_MUL;
        end
        S_CHECK: begin
          if (mdst == M_X) begin
            res <= acc;
          end
          if (i == k) begin
            is_prime <= 1'b0;
            state    <= S_DONE;
          end else if (((mdst == M_X) ? acc : res) == nm1 ||
                       (((mdst == M_X) ? acc : res) == NB'(1) && i == '0)) begin
            widx  <= widx + WI'(1);
            state <= S_WIT;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          a_op <= res; b_op <= res; acc <= '0; mcnt <= CW'(NB);
          mact <= 1'b1; mdst <= M_X;
          i    <= i + CW'(1);
          state <= S_CHECK;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_POW_MUL && mdst == M_B) begin
        b <= acc;
      end
      if (state == S_WIT) begin
        mdst <= M_RES;
      end
    end
  end

  // Squaring chain bookkeeping is in res; verdict only mirrors is_prime.
  always_comb verdict = is_prime;

  // A result strobe only follows the final state.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DONE)
    else $error("done without final state");

  // The reducer never runs while idle.
  assert property (@(posedge clk) disable iff (rst)
    mact |-> busy)
    else $error("multiplier active while idle");

  // Reducer accumulator stays below the modulus.
  assert property (@(posedge clk) disable iff (rst)
    (mact && busy) |=> (acc < n))
    else $error("accumulator not reduced");

  // Even numbers other than two are never reported prime.
  assert property (@(posedge clk) disable iff (rst)
    (done && !n[0] && n != NB'(2)) |-> !verdict)
    else $error("even composite reported prime");

endmodule

[tb/mrpt_checker.sv]
// Checker: watches the command and result channels, predicts primality, compares.
module mrpt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] number,
  input  logic        busy,
  input  logic        done,
  input  logic        is_prime,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  bit verdicts_q[$];

  function automatic logic [31:0] mul_mod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'(p % 64'(m));
  endfunction

  function automatic logic [31:0] pow_mod(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    logic [31:0] r;
    r = 32'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic bit prime_verdict(logic [31:0] n);
    logic [31:0] q;
    logic [31:0] x;
    int k;
    bit ok;
    logic [31:0] wl [8];
    wl = '{2, 3, 5, 7, 11, 13, 17, 19};
    if (!n[0] || n == 1) return n == 2;
    q = n - 1;
    k = 0;
    while (!q[0]) begin
      q = q >> 1;
      k++;
    end
    for (int i = 0; i < 8; i++) begin
      if (wl[i] >= n) break;
      x = pow_mod(wl[i], q, n);
      ok = 0;
      for (int j = 0; j < k; j++) begin
        if (x == n - 1 || (x == 1 && j == 0)) begin
          ok = 1;
          break;
        end
        x = mul_mod(x, x, n);
      end
      if (!ok) return 0;
    end
    return 1;
  endfunction

  assign pending = verdicts_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) verdicts_q.push_back(prime_verdict(number));
      if (done) begin
        if (verdicts_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual is_prime=%0b",
                   $time, is_prime);
          fail_count <= fail_count + 1;
        end else begin
          if (verdicts_q[0] != is_prime) begin
            $display("%0t: is_prime mismatch, expected %0b, actual %0b",
                     $time, verdicts_q[0], is_prime);
            fail_count <= fail_count + 1;
          end
          void'(verdicts_q.pop_front());
        end
      end
    end
  end
endmodule

[tb/tb_miller_rabin_prime_test_unit.sv]
// Testbench top: drives numbers into the prime test unit and reports the verdict.
module tb_miller_rabin_prime_test_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [31:0] number = '0;
  logic        busy, done, is_prime;
  int          fail_count, pending;

  always #1 clk = ~clk;

  miller_rabin_prime_test_unit dut (
    .clk(clk), .rst(rst), .start(start), .number(number),
    .busy(busy), .done(done), .is_prime(is_prime)
  );

  mrpt_checker chk (
    .clk(clk), .rst(rst), .start(start), .number(number), .busy(busy),
    .done(done), .is_prime(is_prime), .fail_count(fail_count), .pending(pending)
  );

  // Offer one transaction; start stays up until busy drops at an edge.
  task automatic send_number(input logic [31:0] n, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 22) begin
        start <= 0;
        @(posedge clk);
      end
    end
    start  <= 1;
    number <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random odd numbers mostly; small ones often, primes by luck.
  function automatic logic [31:0] pick_number();
    logic [31:0] n;
    case ($urandom_range(9))
      0:       n = $urandom;
      1:       n = $urandom_range(64);
      2:       n = 32'($urandom_range(4000)) | 32'd1;
      3:       n = {1'b1, 31'($urandom)} | 32'd1;
      4:       n = 32'($urandom_range(1 << 20)) | 32'd1;
      default: n = $urandom | 32'd1;
    endcase
    return n;
  endfunction

  // Directed corners: zero, one, two, three, small witnesses, pseudoprimes, extremes.
  logic [31:0] corners [] = '{0, 1, 2, 3, 4, 5, 7, 9, 19, 21, 23, 25, 561, 2047,
                              1373653, 25326001, 32'd3215031751, 2147483647,
                              32'd4294967291, 32'd4294967295, 32'd4294967294,
                              32'h8000_0000, 32'h8000_0001,
                              32'h5555_5555, 32'hAAAA_AAAB};

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (corners[i]) send_number(corners[i], 1);
    // hold off until every outstanding verdict is back
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 265; i++)
      send_number(pick_number(), !(i >= 100 && i < 160));
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("miller_rabin_prime_test_unit test passed");
    else
      $display("miller_rabin_prime_test_unit test failed");
    $finish;
  end

  // Watchdog: ~290 items at the worst case each, several times over.
  initial begin
    #100_000_000;
    $display("miller_rabin_prime_test_unit test failed");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/mrpt_pkg.sv
hw/rtl/miller_rabin_prime_test_unit.sv
tb/mrpt_checker.sv
tb/tb_miller_rabin_prime_test_unit.sv
